[design/srtfs_pkg.sv]
package srtfs_pkg;

  // register reset values
  localparam logic [16:0] TILE_ROWS_RESET = 17'd64;
  localparam logic [16:0] ROW_COUNT_RESET = 17'd65536;
  localparam int unsigned MAX_ROWS_DEFAULT = 65536;

  // largest schedule slot, tile end fields saturate here
  localparam logic [16:0] SLOT_MAX = 17'h1FFFF;

  // register codes, taken from paddr[2]
  localparam logic REG_TILE_ROWS = 1'b0;
  localparam logic REG_ROW_COUNT = 1'b1;

  // stream widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 120;
  localparam int unsigned OUT_USER_W = 2;

  // one result, everything except the tile index
  typedef struct packed {
    logic [15:0] row_index;
    logic        is_fused;
    logic [16:0] slot;
    logic        tile_done;
    logic [16:0] tile_start_slot;
    logic [16:0] tile_fused_start;
    logic [16:0] tile_next_start;
    logic [16:0] unfused_total;
    logic        last_row;
  } res_t;

  // clamp a schedule position to the slot range
  function automatic logic [16:0] sat_slot(input logic [18:0] v);
    logic [16:0] r;
    if (v > {2'b00, SLOT_MAX}) begin
      r = SLOT_MAX;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

[design/sparse_row_tile_fusion_scheduler_core.sv]
// Sparse-row tile fusion scheduler.
// Input stream: one nonzero per transaction. s_tdata carries the column index,
// s_tuser the has-entry flag (0 for an empty row), s_tlast closes the row.
// Output stream: one transaction per closed row with its index, tile, fused
// flag and schedule slot; on the last row of a tile the tile's start, fused
// start and next start slots (zero otherwise); the running unfused count.
// m_tlast marks the final configured row. Rows past the configured count and
// items that neither carry an entry nor end a row give no output.
// Configuration: APB, tile_rows at 0x0, row_count at 0x4, written while idle.
// Throughput: one input transaction per cycle while the receiver takes results.
// The tile index is formed by the restoring divider stages behind the result
// register, one quotient bit per stage.
// When the receiver stalls the whole pipeline holds and s_tready falls, so
// nothing is lost. Reset clears all row and slot counters, empties the
// pipeline and restores tile_rows to 64 and row_count to 65536.
module sparse_row_tile_fusion_scheduler_core #(
  parameter int unsigned MAX_ROWS = srtfs_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [srtfs_pkg::IN_DATA_W-1:0]     s_tdata,  // column[15:0]
  input  logic                                s_tuser,  // has_entry
  input  logic                                s_tlast,  // row_end
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // row_index[15:0], tile_index[31:16], slot[48:32], tile_start_slot[65:49],
  // tile_fused_start[82:66], tile_next_start[99:83], unfused_total[116:100]
  output logic [srtfs_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [srtfs_pkg::OUT_USER_W-1:0]    m_tuser,  // is_fused[0], tile_done[1]
  output logic                                m_tlast,  // last_row
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  // rows never exceed the 17-bit row_count register
  localparam int unsigned EFF_ROWS = (MAX_ROWS < 131071) ? MAX_ROWS : 131071;
  localparam int unsigned RW       = $clog2(EFF_ROWS + 1);
  localparam logic [16:0] EFF_ROWS_V = 17'(EFF_ROWS);

  // configuration registers
  logic [16:0] tile_rows;
  logic [16:0] row_count;

  // scheduler state
  logic [RW-1:0] current_row;
  logic [RW-1:0] tile_first_row;
  logic          row_escapes_tile;
  logic [16:0]   fused_in_tile;
  logic [17:0]   tile_base_slot;
  logic [16:0]   unfused_seen;

  // divider pipeline, stage 0 is the result register
  logic              vld       [0:RW];
  srtfs_pkg::res_t   pay       [0:RW];
  logic [RW-1:0]     num       [0:RW];
  logic [16:0]       den       [0:RW];
  logic [16:0]       rem_q     [0:RW];
  logic [RW-1:0]     quot      [0:RW];

  logic        en;
  logic        accept;
  logic [15:0] column;
  logic        has_entry;
  logic        row_end;

  logic [16:0] rows;
  logic [16:0] tsize;
  logic        active;
  logic [17:0] tile_end_raw;
  logic [16:0] tile_end;
  logic [16:0] first_ext;
  logic [17:0] row_plus;
  logic        escape_now;
  logic        esc;
  logic        fused;
  logic [16:0] tile_len;
  logic [18:0] fused_start;
  logic [18:0] slot_fused;
  logic [18:0] next_start;
  logic        done;
  logic        last;
  logic        take;
  logic        emit;
  srtfs_pkg::res_t res;

  assign column    = s_tdata[15:0];
  assign has_entry = s_tuser;
  assign row_end   = s_tlast;

  // pipeline advances unless the output holds a result nobody takes
  assign en       = !vld[RW] || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;

  // apb register file
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      srtfs_pkg::REG_TILE_ROWS: prdata = {15'd0, tile_rows};
      srtfs_pkg::REG_ROW_COUNT: prdata = {15'd0, row_count};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_rows <= srtfs_pkg::TILE_ROWS_RESET;
      row_count <= srtfs_pkg::ROW_COUNT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        srtfs_pkg::REG_TILE_ROWS: tile_rows <= pwdata[16:0];
        srtfs_pkg::REG_ROW_COUNT: row_count <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // per-item row and tile evaluation
  always_comb begin
    rows         = (row_count < EFF_ROWS_V) ? row_count : EFF_ROWS_V;
    tsize        = (tile_rows == 17'd0) ? 17'd1 : tile_rows;
    first_ext    = 17'(tile_first_row);
    active       = 17'(current_row) < rows;
    tile_end_raw = {1'b0, first_ext} + {1'b0, tsize};
    tile_end     = (tile_end_raw > {1'b0, rows}) ? rows : tile_end_raw[16:0];
    escape_now   = has_entry &&
                   ({1'b0, column} < first_ext || {1'b0, column} >= tile_end);
    esc          = row_escapes_tile || escape_now;
    fused        = !esc;
    tile_len     = tile_end - first_ext;
    fused_start  = {1'b0, tile_base_slot} + {2'b00, tile_len};
    slot_fused   = fused_start + {2'b00, fused_in_tile};
    next_start   = slot_fused + {18'd0, fused};
    row_plus     = 18'(current_row) + 18'd1;
    done         = row_plus >= {1'b0, tile_end};
    last         = row_plus == {1'b0, rows};
    take         = accept && active;
    emit         = take && row_end;

    res.row_index        = 16'(current_row);
    res.is_fused         = fused;
    res.slot             = fused ? srtfs_pkg::sat_slot(slot_fused) : unfused_seen;
    res.tile_done        = done;
    res.tile_start_slot  = done ? srtfs_pkg::sat_slot({1'b0, tile_base_slot}) : 17'd0;
    res.tile_fused_start = done ? srtfs_pkg::sat_slot(fused_start) : 17'd0;
    res.tile_next_start  = done ? srtfs_pkg::sat_slot(next_start) : 17'd0;
    res.unfused_total    = unfused_seen + {16'd0, !fused};
    res.last_row         = last;
  end

  // scheduler state update
  always_ff @(posedge clk) begin
    if (rst) begin
      current_row      <= '0;
      tile_first_row   <= '0;
      row_escapes_tile <= 1'b0;
      fused_in_tile    <= '0;
      tile_base_slot   <= '0;
      unfused_seen     <= '0;
    end else if (take) begin
      if (!row_end) begin
        row_escapes_tile <= esc;
      end else begin
        row_escapes_tile <= 1'b0;
        current_row      <= RW'(row_plus);
        unfused_seen     <= unfused_seen + {16'd0, !fused};
        if (done) begin
          tile_base_slot <= next_start[17:0];
          tile_first_row <= RW'(row_plus);
          fused_in_tile  <= '0;
        end else begin
          fused_in_tile  <= fused_in_tile + {16'd0, fused};
        end
      end
    end
  end

  // result register, also loads the divider operands
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay[0]   <= res;
      num[0]   <= tile_first_row;
      den[0]   <= tsize;
      rem_q[0] <= '0;
      quot[0]  <= '0;
    end
  end

  // restoring divider stages for the tile index, msb first
  for (genvar k = 0; k < RW; k++) begin : g_div
    logic [17:0]   trial;
    logic          ge;
    logic [16:0]   rem_next;
    logic [RW-1:0] quot_next;

    always_comb begin
      trial     = {rem_q[k], num[k][RW-1-k]};
      ge        = trial >= {1'b0, den[k]};
      rem_next  = ge ? 17'(trial - {1'b0, den[k]}) : trial[16:0];
      quot_next = quot[k];
      quot_next[RW-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pay[k+1]   <= pay[k];
        num[k+1]   <= num[k];
        den[k+1]   <= den[k];
        rem_q[k+1] <= rem_next;
        quot[k+1]  <= quot_next;
      end
    end
  end

  // output packing
  logic [15:0] tile_index;
  assign tile_index = 16'(quot[RW]);

  assign m_tvalid = vld[RW];
  assign m_tdata  = {3'd0,
                     pay[RW].unfused_total,
                     pay[RW].tile_next_start,
                     pay[RW].tile_fused_start,
                     pay[RW].tile_start_slot,
                     pay[RW].slot,
                     tile_index,
                     pay[RW].row_index};
  assign m_tuser  = {pay[RW].tile_done, pay[RW].is_fused};
  assign m_tlast  = pay[RW].last_row;

endmodule

[verif/row_schedule_checker.sv]
module row_schedule_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  input  logic                                 s_tready,
  input  logic [srtfs_pkg::IN_DATA_W-1:0]      s_tdata,   // column[15:0]
  input  logic                                 s_tuser,   // has_entry
  input  logic                                 s_tlast,   // row_end
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  // row_index[15:0], tile_index[31:16], slot[48:32], tile_start_slot[65:49],
  // tile_fused_start[82:66], tile_next_start[99:83], unfused_total[116:100]
  input  logic [srtfs_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic [srtfs_pkg::OUT_USER_W-1:0]     m_tuser,   // is_fused[0], tile_done[1]
  input  logic                                 m_tlast,   // last_row
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  input  logic                                 pready,
  output int                                   errors,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // one scheduled row as the block should report it
  typedef struct packed {
    logic [15:0] row_index;
    logic [15:0] tile_index;
    logic        is_fused;
    logic [16:0] slot;
    logic        tile_done;
    logic [16:0] tile_start_slot;
    logic [16:0] tile_fused_start;
    logic [16:0] tile_next_start;
    logic [16:0] unfused_total;
    logic        last_row;
  } row_sched_t;

  row_sched_t  due_rows[$];

  // register copies
  logic [16:0] cfg_tile_rows;
  logic [16:0] cfg_row_count;

  // scheduler state
  logic [16:0] cur_row;
  logic [16:0] tile_first;
  logic        row_escapes;
  logic [16:0] fused_cnt;
  logic [17:0] base_slot;
  logic [16:0] unfused_cnt;

  // clamp a schedule position into the slot range
  function automatic logic [16:0] clamp_slot(input int unsigned v);
    logic [16:0] r;
    if (v > int'(srtfs_pkg::SLOT_MAX)) begin
      r = srtfs_pkg::SLOT_MAX;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  // advance the schedule by one accepted transaction, queue the row it closes
  function automatic void schedule_item(input logic [15:0] column, input logic has_entry,
                                        input logic row_end);
    int unsigned rows;
    int unsigned tsize;
    int unsigned tile_end;
    int unsigned tile_len;
    int unsigned fused_start;
    int unsigned next_start;
    int unsigned slot_v;
    logic        fused;
    logic        done;
    row_sched_t  r;
    rows  = (cfg_row_count < srtfs_pkg::MAX_ROWS_DEFAULT) ? cfg_row_count
                                                          : srtfs_pkg::MAX_ROWS_DEFAULT;
    tsize = (cfg_tile_rows == 0) ? 1 : cfg_tile_rows;
    if (cur_row >= rows) return;
    tile_end = tile_first + tsize;
    if (tile_end > rows) tile_end = rows;
    if (has_entry && (column < tile_first || column >= tile_end)) row_escapes = 1'b1;
    if (!row_end) return;

    tile_len    = tile_end - tile_first;
    fused_start = base_slot + tile_len;
    fused       = !row_escapes;
    if (fused) begin
      slot_v    = fused_start + fused_cnt;
      fused_cnt = fused_cnt + 1;
    end else begin
      slot_v      = unfused_cnt;
      unfused_cnt = unfused_cnt + 1;
    end
    next_start = fused_start + fused_cnt;
    done       = (cur_row + 1 >= tile_end);

    r            = '0;
    r.row_index  = cur_row[15:0];
    r.tile_index = 16'(tile_first / tsize);
    r.is_fused   = fused;
    r.slot       = clamp_slot(slot_v);
    r.tile_done  = done;
    if (done) begin
      r.tile_start_slot  = clamp_slot(base_slot);
      r.tile_fused_start = clamp_slot(fused_start);
      r.tile_next_start  = clamp_slot(next_start);
    end
    r.unfused_total = unfused_cnt;
    r.last_row      = (cur_row + 1 == rows);
    due_rows = {due_rows, r};

    // tile wrap
    if (done) begin
      base_slot  = next_start[17:0];
      tile_first = cur_row + 1;
      fused_cnt  = '0;
    end
    row_escapes = 1'b0;
    cur_row     = cur_row + 1;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // compare one output transaction with the oldest queued row
  function automatic void check_result();
    row_sched_t want;
    if (due_rows.size() == 0) begin
      $display("%0t ns: unexpected result, expected none actual row_index %0d",
               $time, m_tdata[15:0]);
      errors++;
      return;
    end
    want = due_rows.pop_front();
    check_field("row_index", want.row_index, m_tdata[15:0]);
    check_field("tile_index", want.tile_index, m_tdata[31:16]);
    check_field("is_fused", want.is_fused, m_tuser[0]);
    check_field("slot", want.slot, m_tdata[48:32]);
    check_field("tile_done", want.tile_done, m_tuser[1]);
    check_field("tile_start_slot", want.tile_start_slot, m_tdata[65:49]);
    check_field("tile_fused_start", want.tile_fused_start, m_tdata[82:66]);
    check_field("tile_next_start", want.tile_next_start, m_tdata[99:83]);
    check_field("unfused_total", want.unfused_total, m_tdata[116:100]);
    check_field("last_row", want.last_row, m_tlast);
  endfunction

  // watch config, input and output channels
  always @(posedge clk) begin
    if (rst) begin
      cfg_tile_rows = srtfs_pkg::TILE_ROWS_RESET;
      cfg_row_count = srtfs_pkg::ROW_COUNT_RESET;
      cur_row       = '0;
      tile_first    = '0;
      row_escapes   = 1'b0;
      fused_cnt     = '0;
      base_slot     = '0;
      unfused_cnt   = '0;
      errors        = 0;
      due_rows.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          srtfs_pkg::REG_TILE_ROWS: begin
            cfg_tile_rows = pwdata[16:0];
          end
          srtfs_pkg::REG_ROW_COUNT: begin
            cfg_row_count = pwdata[16:0];
          end
          default: begin
          end
        endcase
      end
      if (s_tvalid && s_tready) schedule_item(s_tdata[15:0], s_tuser, s_tlast);
      if (m_tvalid && m_tready) check_result();
    end
    pending = due_rows.size();
  end

endmodule

[verif/tb_sparse_row_tile_fusion_scheduler_core.sv]
module tb_sparse_row_tile_fusion_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1150;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 30;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [srtfs_pkg::IN_DATA_W-1:0]     s_tdata;   // column[15:0]
  logic                                s_tuser;   // has_entry
  logic                                s_tlast;   // row_end
  logic                                m_tvalid;
  logic                                m_tready;
  // row_index[15:0], tile_index[31:16], slot[48:32], tile_start_slot[65:49],
  // tile_fused_start[82:66], tile_next_start[99:83], unfused_total[116:100]
  logic [srtfs_pkg::OUT_DATA_W-1:0]    m_tdata;
  logic [srtfs_pkg::OUT_USER_W-1:0]    m_tuser;   // is_fused[0], tile_done[1]
  logic                                m_tlast;   // last_row
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [2:0]                          paddr;
  logic [31:0]                         pwdata;
  logic [31:0]                         prdata;
  logic                                pready;

  int fail_cnt;
  int pending_cnt;
  int row_pos;
  int eff_rows;
  int items_sent;
  int quiet_cycles;
  bit tx_gaps;
  bit rx_gaps;

  sparse_row_tile_fusion_scheduler_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  row_schedule_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .errors   (fail_cnt),
    .pending  (pending_cnt)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver backpressure in bursts
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (rx_gaps && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic apb_write(input logic reg_idx, input logic [16:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {15'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == srtfs_pkg::REG_ROW_COUNT) begin
      eff_rows = (value > srtfs_pkg::MAX_ROWS_DEFAULT) ? srtfs_pkg::MAX_ROWS_DEFAULT : value;
    end
    @(negedge clk);
  endtask

  // hold off the sender until every queued row has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one input transaction, with an optional gap in front
  task automatic send_item(input logic [15:0] column, input logic has_entry,
                           input logic row_end);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= column;
    s_tuser  <= has_entry;
    s_tlast  <= row_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (row_end && row_pos < eff_rows) row_pos++;
  endtask

  // mostly near the diagonal, sometimes anywhere or at the extremes
  function automatic logic [15:0] pick_column();
    int c;
    case ($urandom_range(0, 15))
      0: c = $urandom_range(0, 65535);
      1: c = 0;
      2: c = 65535;
      default: c = row_pos + int'($urandom_range(0, 6)) - 3;
    endcase
    if (c < 0) c = 0;
    if (c > 65535) c = 65535;
    return c[15:0];
  endfunction

  // a well-formed row with random content and some ignored noise
  task automatic send_row();
    int  n_ent;
    int  i;
    bit  trailing;
    n_ent    = $urandom_range(0, 4);
    trailing = ($urandom_range(0, 7) == 0);
    if (n_ent == 0) begin
      send_item(16'($urandom), 1'b0, 1'b1);
    end else begin
      for (i = 0; i < n_ent; i++) begin
        if ($urandom_range(0, 11) == 0) send_item(16'($urandom), 1'b0, 1'b0);
        send_item(pick_column(), 1'b1, (i == n_ent - 1) && !trailing);
      end
      if (trailing) send_item(16'($urandom), 1'b0, 1'b1);
    end
  endtask

  // stimulus
  initial begin
    logic [16:0] tile_cfg;
    logic [16:0] rows_cfg;
    int          n_rows;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    s_tlast    = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    row_pos    = 0;
    eff_rows   = srtfs_pkg::MAX_ROWS_DEFAULT;
    items_sent = 0;
    tx_gaps    = 1'b0;
    rx_gaps    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows at reset config
    send_item(16'd0, 1'b1, 1'b0);
    send_item(16'd63, 1'b1, 1'b1);          // fused, both tile edges
    send_item(16'd64, 1'b1, 1'b1);          // just past the tile
    send_item(16'hFFFF, 1'b1, 1'b1);        // top column
    send_item(16'h1234, 1'b0, 1'b1);        // empty row
    send_item(16'hFFFF, 1'b0, 1'b0);        // ignored
    send_item(16'd5, 1'b1, 1'b0);
    send_item(16'h5555, 1'b0, 1'b1);        // closed by an entry-less item
    send_item(16'hAAAA, 1'b1, 1'b0);
    send_item(16'h5555, 1'b1, 1'b1);

    // zero tile size, open tile already passed, short matrix then drops
    drain_results();
    apb_write(srtfs_pkg::REG_TILE_ROWS, 17'd0);
    apb_write(srtfs_pkg::REG_ROW_COUNT, 17'd8);
    send_item(16'd6, 1'b1, 1'b1);
    send_item(16'd7, 1'b1, 1'b1);           // last configured row
    send_item(16'd7, 1'b1, 1'b1);
    send_item(16'd0, 1'b0, 1'b1);

    // zero row count drops everything
    drain_results();
    apb_write(srtfs_pkg::REG_ROW_COUNT, 17'd0);
    send_item(16'd8, 1'b1, 1'b1);
    send_item(16'hFFFF, 1'b0, 1'b1);

    // widest tile, row count above the row limit
    drain_results();
    apb_write(srtfs_pkg::REG_TILE_ROWS, 17'h10000);
    apb_write(srtfs_pkg::REG_ROW_COUNT, 17'h1FFFF);
    repeat (8) send_row();

    // random phases
    while (items_sent < ITEM_TARGET - 150) begin
      drain_results();
      case ($urandom_range(0, 7))
        0: tile_cfg = 17'd1;
        1: tile_cfg = 17'd2;
        2: tile_cfg = 17'd3;
        3: tile_cfg = 17'($urandom_range(4, 16));
        4: tile_cfg = 17'd64;
        5: tile_cfg = 17'h10000;
        6: tile_cfg = 17'($urandom_range(1, 17'h1FFFF));
        default: tile_cfg = 17'd0;
      endcase
      apb_write(srtfs_pkg::REG_TILE_ROWS, tile_cfg);
      case ($urandom_range(0, 3))
        0: rows_cfg = 17'h10000;
        1: rows_cfg = 17'h1FFFF;
        default: rows_cfg = 17'(row_pos + int'($urandom_range(1, 60)));
      endcase
      apb_write(srtfs_pkg::REG_ROW_COUNT, rows_cfg);
      tx_gaps = ($urandom_range(0, 2) != 0);
      rx_gaps = ($urandom_range(0, 2) != 0);
      n_rows  = $urandom_range(10, 60);
      repeat (n_rows) send_row();
    end

    // closing stretch, no gaps on either side
    drain_results();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    apb_write(srtfs_pkg::REG_TILE_ROWS, 17'd1);
    apb_write(srtfs_pkg::REG_ROW_COUNT, 17'h10000);
    while (items_sent < ITEM_TARGET) send_row();

    drain_results();
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
